@@ hdl/sgz_pkg.sv @@
package sgz_pkg;

    // Default sizes of the grid store.
    localparam int MAP_DIM_DEF    = 64;
    localparam int VALUE_BITS_DEF = 8;

    // Fixed widths of the command, result and configuration fields.
    localparam int ROW_W      = 6;
    localparam int IN_VAL_W   = 8;
    localparam int OUT_VAL_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]  REG_MAP_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_MAP_COLS = 2'd1;
    localparam logic [CFG_DATA_W-1:0] MAP_ROWS_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] MAP_COLS_RST = 7'd64;

    // Command codes on the action field.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Window walk: nine reads in row-major order, step 4 is the center.
    localparam logic [3:0] STEP_FIRST    = 4'd1;
    localparam logic [3:0] STEP_ROW_END0 = 4'd2;
    localparam logic [3:0] STEP_ROW_END1 = 4'd5;
    localparam logic [3:0] STEP_CENTER   = 4'd4;
    localparam logic [3:0] STEP_LAST     = 4'd8;

    // The weights sum to 16, so the average is a right shift by four.
    localparam int SUM_SHIFT = 4;

    // Operations handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_RANGE_ERR
    } t_op;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAST
    } t_back_state;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

    // Weight of a window position as a left shift: corners 2, center 4, edges 1.
    function automatic logic [1:0] f_weight_shift(input logic [3:0] step);
        logic [1:0] shift;
        shift = 2'd0;
        if (step == STEP_CENTER) begin
            shift = 2'd2;
        end else if (step inside {4'd0, 4'd2, 4'd6, 4'd8}) begin
            shift = 2'd1;
        end
        return shift;
    endfunction

endpackage

@@ hdl/sgz_ram.sv @@
module sgz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port with registered read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sgz_queue.sv @@
module sgz_queue
    import sgz_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_entry,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output t_q_flags         o_flags
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == CW'(DEPTH));

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count exceeds depth");

    // The fill count moves by one at most and only with a request.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !i_pop) |=> $stable(r_count))
        else $error("queue fill count changed without a request");

    // A pop on an empty queue leaves the read pointer alone.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_count == '0 && !i_push) |=> $stable(r_rptr))
        else $error("read pointer moved on an empty queue");

endmodule

@@ hdl/sgz_front.sv @@
module sgz_front
    import sgz_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(MAP_DIM * MAP_DIM),
    localparam int QW = $bits(t_op) + AW + VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_action,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [ROW_W-1:0]      i_col,
    input  logic [IN_VAL_W-1:0]   i_cell_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_flags              i_qflags,
    output logic                  o_busy,
    output logic                  o_push,
    output logic [QW-1:0]         o_entry
);

    // Coordinate and limit widths.
    localparam int CRD_W = $clog2(MAP_DIM);
    localparam int LIM_W = ($clog2(MAP_DIM + 1) > CFG_DATA_W) ? $clog2(MAP_DIM + 1)
                                                              : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_map_rows;
    logic [CFG_DATA_W-1:0] r_map_cols;
    logic [LIM_W-1:0]      lim_rows, lim_cols;
    logic [LIM_W-1:0]      need_row, need_col;
    logic                  query_err;
    logic                  in_store;
    logic [AW-1:0]         wr_addr, tl_addr;
    logic                  accept;
    t_op                   op;

    // Configuration registers; the port never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_rows <= MAP_ROWS_RST;
            r_map_cols <= MAP_COLS_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MAP_ROWS) begin
                r_map_rows <= i_cfg_data;
            end else if (i_cfg_index == REG_MAP_COLS) begin
                r_map_cols <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // Range check of the window against the grid in use, clamped to the store.
    always_comb begin
        lim_rows  = (LIM_W'(r_map_rows) > LIM_W'(MAP_DIM)) ? LIM_W'(MAP_DIM)
                                                            : LIM_W'(r_map_rows);
        lim_cols  = (LIM_W'(r_map_cols) > LIM_W'(MAP_DIM)) ? LIM_W'(MAP_DIM)
                                                            : LIM_W'(r_map_cols);
        need_row  = LIM_W'(i_row[ROW_W-1:1]) + LIM_W'(2);
        need_col  = LIM_W'(i_col[ROW_W-1:1]) + LIM_W'(2);
        query_err = (need_row >= lim_rows) || (need_col >= lim_cols);
        in_store  = (LIM_W'(i_row) < LIM_W'(MAP_DIM)) && (LIM_W'(i_col) < LIM_W'(MAP_DIM));
    end

    // Linear addresses of the written cell and of the window's top-left cell.
    always_comb begin
        wr_addr = AW'(CRD_W'(i_row)) * AW'(MAP_DIM) + AW'(CRD_W'(i_col));
        tl_addr = AW'(CRD_W'(i_row[ROW_W-1:1])) * AW'(MAP_DIM)
                + AW'(CRD_W'(i_col[ROW_W-1:1]));
    end

    // Classify the request and hand it to the queue.
    always_comb begin
        accept = i_start && !i_qflags.full;
        if (i_action == ACT_QUERY) begin
            op = query_err ? OP_RANGE_ERR : OP_QUERY;
        end else begin
            op = OP_WRITE;
        end
        o_push  = accept && ((i_action == ACT_QUERY) || in_store);
        o_entry = {op, (i_action == ACT_QUERY) ? tl_addr : wr_addr,
                   VALUE_BITS'(i_cell_value)};
    end

    assign o_busy = i_qflags.full;

endmodule

@@ hdl/sgz_back.sv @@
module sgz_back
    import sgz_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(MAP_DIM * MAP_DIM),
    localparam int QW = $bits(t_op) + AW + VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_flags              i_qflags,
    input  logic [QW-1:0]         i_head,
    output logic                  o_pop,
    output logic                  o_ram_en,
    output logic                  o_ram_we,
    output logic [AW-1:0]         o_ram_addr,
    output logic [VALUE_BITS-1:0] o_ram_wdata,
    input  logic [VALUE_BITS-1:0] i_ram_rdata,
    output logic                  o_strobe,
    output logic [OUT_VAL_W-1:0]  o_value,
    output logic                  o_error
);

    localparam int SW = VALUE_BITS + SUM_SHIFT;

    t_back_state           r_state, n_state;
    logic [3:0]            r_step, n_step;
    logic [AW-1:0]         r_addr, n_addr;
    logic [SW-1:0]         r_sum, n_sum;
    logic                  r_strobe, n_strobe;
    logic [OUT_VAL_W-1:0]  r_value, n_value;
    logic                  r_error, n_error;
    t_op                   head_op;
    logic [AW-1:0]         head_addr;
    logic [VALUE_BITS-1:0] head_data;
    logic [3:0]            data_step;
    logic [SW-1:0]         weighted;

    // Queue head fields.
    assign head_op   = t_op'(i_head[QW-1 -: $bits(t_op)]);
    assign head_addr = i_head[VALUE_BITS +: AW];
    assign head_data = i_head[VALUE_BITS-1:0];

    // Read data belongs to the step issued in the previous cycle.
    always_comb begin
        data_step = (r_state == S_LAST) ? STEP_LAST : r_step - 4'd1;
        weighted  = SW'(i_ram_rdata) << f_weight_shift(data_step);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_qflags.empty && head_op == OP_QUERY) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory control, window walk, accumulation and result.
    always_comb begin
        o_pop       = 1'b0;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_addr;
        o_ram_wdata = head_data;
        n_addr      = r_addr;
        n_step      = r_step;
        n_sum       = r_sum;
        n_strobe    = 1'b0;
        n_value     = r_value;
        n_error     = r_error;
        case (r_state)
            S_IDLE: begin
                if (!i_qflags.empty) begin
                    o_pop = 1'b1;
                    case (head_op)
                        OP_WRITE: begin
                            o_ram_en   = 1'b1;
                            o_ram_we   = 1'b1;
                            o_ram_addr = head_addr;
                        end
                        OP_QUERY: begin
                            o_ram_en   = 1'b1;
                            o_ram_addr = head_addr;
                            n_addr     = head_addr + AW'(1);
                            n_step     = STEP_FIRST;
                            n_sum      = '0;
                        end
                        OP_RANGE_ERR: begin
                            n_strobe = 1'b1;
                            n_value  = '0;
                            n_error  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_ram_en = 1'b1;
                n_sum    = r_sum + weighted;
                n_step   = r_step + 4'd1;
                if (r_step == STEP_ROW_END0 || r_step == STEP_ROW_END1) begin
                    n_addr = r_addr + AW'(MAP_DIM - 2);
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_LAST: begin
                n_strobe = 1'b1;
                n_value  = OUT_VAL_W'((r_sum + weighted) >> SUM_SHIFT);
                n_error  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_sum   <= n_sum;
        r_value <= n_value;
        r_error <= n_error;
    end

    assign o_strobe = r_strobe;
    assign o_value  = r_value;
    assign o_error  = r_error;

    // A result follows either the last read of a window or a failed query.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_LAST
                           || (r_state == S_IDLE && o_pop && head_op == OP_RANGE_ERR)))
        else $error("result strobe without a finished query");

    // The final add comes only after all nine reads were issued.
    a_last_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> $past(r_state == S_READ && r_step == STEP_LAST))
        else $error("window walk ended early");

    // No cell is written while a window is being read.
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!o_ram_we && !o_pop))
        else $error("memory write or queue pop during a window walk");

    // A failed query reports zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_error) |-> (r_value == '0))
        else $error("range error result with nonzero value");

endmodule

@@ hdl/grid_zoom_smooth_filter_top.sv @@
// Channel   Direction  Handshake                    Payload
// command   in         start, busy                  i_action, i_row, i_col, i_cell_value
// result    out        o_result_strobe              o_smoothed_value, o_range_error
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// A write takes a single access to the grid memory. A query walks its 3x3 window with one read
// per cycle from the single-port grid memory and adds the last cell in the cycle after the
// last read; its result strobe is registered, as is the strobe of a range error.
// Reset is synchronous and active low; the grid memory is not cleared.
// busy is high while the two-entry command queue is full. Results cannot be held off.
module grid_zoom_smooth_filter_top
    import sgz_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [ROW_W-1:0]      i_col,
    input  logic [IN_VAL_W-1:0]   i_cell_value,
    output logic                  o_result_strobe,
    output logic [OUT_VAL_W-1:0]  o_smoothed_value,
    output logic                  o_range_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAP_DIM * MAP_DIM);
    localparam int QW = $bits(t_op) + AW + VALUE_BITS;

    t_q_flags              qflags;
    logic                  push, pop;
    logic [QW-1:0]         entry, head;
    logic                  ram_en, ram_we;
    logic [AW-1:0]         ram_addr;
    logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

    // Front part: configuration, request classification and address setup.
    sgz_front #(
        .MAP_DIM    (MAP_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_value (i_cell_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_qflags     (qflags),
        .o_busy       (busy),
        .o_push       (push),
        .o_entry      (entry)
    );

    // Command queue between the two parts.
    sgz_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (qflags)
    );

    // Back part: memory writes and window accumulation.
    sgz_back #(
        .MAP_DIM    (MAP_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qflags    (qflags),
        .i_head      (head),
        .o_pop       (pop),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_strobe    (o_result_strobe),
        .o_value     (o_smoothed_value),
        .o_error     (o_range_error)
    );

    // Grid store.
    sgz_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAP_DIM * MAP_DIM)
    ) u_grid (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule
